// ----- design/tm3_pkg.sv -----
// ----------------------------------------------------------------------------
// tm3_pkg
// Shared types and constants of the 3x3 threshold morphology block.
// ----------------------------------------------------------------------------
`default_nettype none

package tm3_pkg;

  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 13;
  localparam int unsigned KSEL_W   = 3;
  localparam int unsigned WIN_BITS = 9;

  // Register reset values
  localparam logic [LUMA_W-1:0] THRESHOLD_RST  = 8'd140;
  localparam logic [KSEL_W-1:0] KERNEL_RST     = 3'd1;
  localparam logic              ERODE_RST      = 1'b0;
  localparam int unsigned       FRAME_W_RST    = 640;
  localparam int unsigned       FRAME_H_RST    = 480;
  localparam logic [LUMA_W-1:0] LEVEL_LOW_RST  = 8'd16;
  localparam logic [LUMA_W-1:0] LEVEL_HIGH_RST = 8'd235;

  typedef enum logic [CFG_AW-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_KERNEL       = 3'd1,
    REG_ERODE        = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4,
    REG_LEVEL_LOW    = 3'd5,
    REG_LEVEL_HIGH   = 3'd6
  } reg_e;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // Neighbor masks, bit row*3+col of the window
  localparam logic [WIN_BITS-1:0] KERNEL_MASK [8] = '{
    9'h1FF,  // full 3x3
    9'h0BA,  // cross
    9'h038,  // horizontal line
    9'h092,  // vertical line
    9'h054,  // anti-diagonal
    9'h111,  // diagonal
    9'h007,  // top row
    9'h1C0   // bottom row
  };

  // Request as decoded by the position tracker
  typedef struct packed {
    logic is_pixel;  // pixel request, else drain
    logic bin;       // binarized luma
    logic emit;      // request releases one result
    logic interior;  // released position is off the frame border
    logic last;      // released position is the final pixel of the frame
  } item_t;

endpackage

`default_nettype wire

// ----- design/tm3_line_store.sv -----
// ----------------------------------------------------------------------------
// tm3_line_store
// Two-bit-per-column line store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tm3_line_store #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [1:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [1:0]    rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/tm3_ctrl.sv -----
// ----------------------------------------------------------------------------
// tm3_ctrl
// Raster position and pending-count tracker; decodes each accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module tm3_ctrl #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      restart_i,
  input  wire logic                      accept_i,
  input  wire logic                      cmd_i,
  input  wire logic [tm3_pkg::LUMA_W-1:0] luma_i,
  input  wire logic [tm3_pkg::LUMA_W-1:0] threshold_i,
  input  wire logic [WW-1:0]             width_i,
  input  wire logic [HW-1:0]             height_i,
  output tm3_pkg::item_t                 item_o,
  output logic      [CW-1:0]             col_o
);

  import tm3_pkg::*;

  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic [PW-1:0] pend_q, pend_d;

  logic pix, emit;
  logic in_col_last, in_row_last, out_col_last, out_row_last;

  assign pix          = (cmd_i == CMD_PIXEL);
  assign in_col_last  = (WW'(in_col_q) + WW'(1)) == width_i;
  assign in_row_last  = (HW'(in_row_q) + HW'(1)) == height_i;
  assign out_col_last = (WW'(out_col_q) + WW'(1)) == width_i;
  assign out_row_last = (HW'(out_row_q) + HW'(1)) == height_i;

  // A pixel releases the oldest result once more than width are pending;
  // a drain releases one only between frames.
  always_comb begin
    if (pix) begin
      emit = pend_q > PW'(width_i);
    end else begin
      emit = (in_col_q == '0) && (in_row_q == '0) && (pend_q != '0);
    end
  end

  always_comb begin
    item_o.is_pixel = pix;
    item_o.bin      = luma_i >= threshold_i;
    item_o.emit     = emit;
    item_o.interior = (out_row_q != '0) && (out_col_q != '0) &&
                      !out_row_last && !out_col_last;
    item_o.last     = out_row_last && out_col_last;
  end

  assign col_o = in_col_q;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    if (accept_i) begin
      if (pix) begin
        if (in_col_last) begin
          in_col_d = '0;
          in_row_d = in_row_last ? '0 : in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_last ? '0 : out_row_q + RW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
      pend_d = pend_q + PW'(pix) - PW'(emit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (restart_i) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/tm3_window.sv -----
// ----------------------------------------------------------------------------
// tm3_window
// Line store read-modify-write stage: window update, kernel test, write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module tm3_window #(
  parameter int unsigned CW = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       restart_i,
  input  wire logic                       accept_i,
  input  wire tm3_pkg::item_t             item_i,
  input  wire logic [CW-1:0]              col_i,
  input  wire logic [1:0]                 rdata_i,
  input  wire logic                       out_free_i,
  input  wire logic [tm3_pkg::KSEL_W-1:0] kernel_i,
  input  wire logic                       erode_i,
  output logic                            in_ready_o,
  output logic                            we_o,
  output logic      [CW-1:0]              waddr_o,
  output logic      [1:0]                 wdata_o,
  output logic                            res_load_o,
  output logic                            res_high_o,
  output logic                            res_last_o
);

  import tm3_pkg::*;

  logic                valid_q, valid_d;
  item_t               item_q;
  logic [CW-1:0]       col_q;
  logic                fwd_q;
  logic [1:0]          fwd_data_q;
  logic [WIN_BITS-1:0] win_q, win_new, mask;
  logic [1:0]          stored;
  logic                adv, centre, high;

  // Take the column just written when the next request reads the same one
  assign stored = fwd_q ? fwd_data_q : rdata_i;

  always_comb begin
    if (item_q.is_pixel) begin
      win_new = ((win_q >> 1) & 9'h0DB) |
                (WIN_BITS'(stored[1]) << 2) |
                (WIN_BITS'(stored[0]) << 5) |
                (WIN_BITS'(item_q.bin) << 8);
    end else begin
      win_new = win_q;
    end
  end

  assign mask   = KERNEL_MASK[kernel_i];
  assign centre = win_new[4];

  always_comb begin
    if (erode_i) begin
      high = centre && ((mask & ~win_new) == '0);
    end else begin
      high = centre || ((mask & win_new) != '0);
    end
  end

  assign adv        = valid_q && (!item_q.emit || out_free_i);
  assign in_ready_o = !valid_q || adv;

  assign we_o    = adv && item_q.is_pixel;
  assign waddr_o = col_q;
  assign wdata_o = {stored[0], item_q.bin};

  assign res_load_o = adv && item_q.emit;
  assign res_high_o = item_q.interior && high;
  assign res_last_o = item_q.last;

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (adv) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      win_q   <= '0;
    end else if (restart_i) begin
      valid_q <= 1'b0;
      win_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (adv) begin
        win_q <= win_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q     <= item_i;
      col_q      <= col_i;
      fwd_q      <= valid_q && item_q.is_pixel && (col_q == col_i);
      fwd_data_q <= wdata_o;
    end
  end

endmodule

`default_nettype wire

// ----- design/threshold_morphology_3x3_top.sv -----
// ----------------------------------------------------------------------------
// threshold_morphology_3x3_top
// Binarize a raster luma stream and apply 3x3 dilation or erosion.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser 0 carries a pixel in tdata,
// tuser 1 is a drain that releases one pending result between frames.
// Results leave on m_axis, tdata level_low or level_high, tlast on the final
// pixel of a frame. Each pixel request releases the result of the pixel
// width+1 requests earlier; the frame tail is released by drains or by the
// next frame's pixels.
// One request per cycle is sustained while m_axis takes results. The line
// store read and the request register load at the accepting edge; the
// window update, kernel test and write-back then work from the request
// register and load any released result into the output register.
// If m_axis stalls, the result holds in the output register and the stage
// behind it keeps working until it also holds a result; then s_axis_tready
// drops. The user is to write registers through cfg only while the block is
// idle; the block does not enforce this. Writing the frame width or
// height restarts the stream and drops pending results. Reset loads the
// register defaults and empties the pipeline; the line store is not
// cleared, its stale entries only feed border pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_morphology_3x3_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // slave stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [7:0] luma_in
  input  wire logic [0:0]                 s_axis_tuser,  // [0] command
  // master stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [7:0]                 m_axis_tdata,  // [7:0] luma_out
  output logic                            m_axis_tlast,
  // configuration
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [tm3_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire logic [tm3_pkg::CFG_DW-1:0] cfg_data_i
);

  import tm3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam logic [WW-1:0] WIDTH_RST =
    WW'((FRAME_W_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_W_RST);
  localparam logic [HW-1:0] HEIGHT_RST =
    HW'((FRAME_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_H_RST);

  logic [LUMA_W-1:0] threshold_q, level_low_q, level_high_q;
  logic [KSEL_W-1:0] kernel_q;
  logic              erode_q;
  logic [WW-1:0]     width_q, width_eff;
  logic [HW-1:0]     height_q, height_eff;

  logic cfg_we, restart, accept;
  logic in_ready, out_free;
  logic we;
  logic [CW-1:0] waddr, col;
  logic [1:0]    wdata, rdata;
  logic res_load, res_high, res_last;
  item_t item;

  logic              out_valid_q;
  logic [LUMA_W-1:0] out_luma_q;
  logic              out_last_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && ((cfg_addr_i == REG_FRAME_WIDTH) ||
                                  (cfg_addr_i == REG_FRAME_HEIGHT));

  // Clamp dimensions to 1..MAX on write
  always_comb begin
    if (cfg_data_i == '0) begin
      width_eff = WW'(1);
    end else if ((CFG_DW + 1)'(cfg_data_i) > (CFG_DW + 1)'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      height_eff = HW'(1);
    end else if ((CFG_DW + 1)'(cfg_data_i) > (CFG_DW + 1)'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      kernel_q     <= KERNEL_RST;
      erode_q      <= ERODE_RST;
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      level_low_q  <= LEVEL_LOW_RST;
      level_high_q <= LEVEL_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr_i)
        REG_THRESHOLD:    threshold_q  <= cfg_data_i[LUMA_W-1:0];
        REG_KERNEL:       kernel_q     <= cfg_data_i[KSEL_W-1:0];
        REG_ERODE:        erode_q      <= cfg_data_i[0];
        REG_FRAME_WIDTH:  width_q      <= width_eff;
        REG_FRAME_HEIGHT: height_q     <= height_eff;
        REG_LEVEL_LOW:    level_low_q  <= cfg_data_i[LUMA_W-1:0];
        REG_LEVEL_HIGH:   level_high_q <= cfg_data_i[LUMA_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = in_ready;
  assign accept        = s_axis_tvalid && in_ready;

  tm3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser[0]),
    .luma_i      (s_axis_tdata),
    .threshold_i (threshold_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .item_o      (item),
    .col_o       (col)
  );

  tm3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept && item.is_pixel),
    .raddr_i (col),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  tm3_window #(
    .CW (CW)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .accept_i   (accept),
    .item_i     (item),
    .col_i      (col),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .kernel_i   (kernel_q),
    .erode_i    (erode_q),
    .in_ready_o (in_ready),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .res_load_o (res_load),
    .res_high_o (res_high),
    .res_last_o (res_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_luma_q <= res_high ? level_high_q : level_low_q;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_luma_q;
  assign m_axis_tlast  = out_last_q;

  // A result only loads into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over an untaken result");

  // Output valid only rises from a load
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_load))
    else $error("output valid rose without a result load");

  // The final pixel of a frame lies on the border
  a_last_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_last) |-> !res_high)
    else $error("final pixel of frame evaluated high");

endmodule

`default_nettype wire
